FILE: rtl/ntab_pkg.sv
// ----------------------------------------------------------------------------
// ntab_pkg
// Shared types and constants of the neighbour table.
// ----------------------------------------------------------------------------
package ntab_pkg;

    localparam int ID_W    = 8;
    localparam int STAMP_W = 32;
    localparam int DIST_W  = 8;
    localparam int TMO_W   = 16;
    localparam int CNT_W   = 5;    // width of the reported count
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOOD_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;

    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd32;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
        logic [DIST_W-1:0]  distance;
    } t_entry;

endpackage

FILE: rtl/neighbor_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top
// Neighbour table with aging: message items refresh or append, tick items
// drop stale entries; every item reports count, mean distance and food flag.
// ----------------------------------------------------------------------------
// Item time is set by the single-port entry memory walk and the
//   bit-serial divider.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous, active low; table emptied, food id 0, timeout 32.
// The result strobe is one cycle wide; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top #(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_action,
    input  logic [ntab_pkg::STAMP_W-1:0]      i_now,
    input  logic [ntab_pkg::ID_W-1:0]         i_sender_id,
    input  logic [ntab_pkg::DIST_W-1:0]       i_distance,
    // result
    output logic                              o_result_valid,
    output logic [ntab_pkg::CNT_W-1:0]        o_neighbor_count,
    output logic [ntab_pkg::DIST_W-1:0]       o_mean_distance,
    output logic                              o_food_in_range,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ntab_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ntab_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ntab_pkg::*;

    // IW indexes the memory, CW holds a count up to MAX_NEIGHBORS
    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    // widest possible distance sum
    localparam int SW = $clog2(MAX_NEIGHBORS * 255 + 1);

    localparam logic [CW-1:0] C_ONE  = CW'(1);
    localparam logic [CW-1:0] C_FULL = CW'(MAX_NEIGHBORS);
    localparam logic [IW-1:0] I_LAST = IW'(MAX_NEIGHBORS - 1);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SEARCH  = 7'b0000010,   // walk entries looking for the sender id
        S_TK_RD   = 7'b0000100,   // issue read of the slot under test
        S_TK_TEST = 7'b0001000,   // age check, fetch last entry if stale
        S_TK_MOVE = 7'b0010000,   // last entry moves into the freed slot
        S_SUM     = 7'b0100000,   // walk entries: distance sum, food check
        S_DIV     = 7'b1000000    // mean = sum / count
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [ID_W-1:0]   r_food_id;
    logic [TMO_W-1:0]  r_timeout;

    // item latched at acceptance
    logic [STAMP_W-1:0] r_now;
    logic [ID_W-1:0]    r_id;
    logic [DIST_W-1:0]  r_dist;

    // walk pointers: r_ptr ascends (search, sum), r_k descends (aging)
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_k;
    logic              r_pend;      // memory read data is valid this cycle
    logic [IW-1:0]     r_pidx;      // slot that read data belongs to
    logic [SW-1:0]     r_sum;
    logic              r_food;
    logic              r_div_start;

    logic                r_res_valid;
    logic [CNT_W-1:0]    r_res_count;
    logic [DIST_W-1:0]   r_res_mean;
    logic                r_res_food;

    // entry memory, registered read
    t_entry            r_mem [MAX_NEIGHBORS];
    t_entry            r_rd_data;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;

    logic [CW-1:0]     k_m1;
    logic [CW-1:0]     last;
    logic              hit_now;
    logic              full;
    logic              expired;
    logic [STAMP_W-1:0] age;
    logic [IW-1:0]     msg_slot;
    logic              search_end;
    logic              div_done;
    logic [SW-1:0]     div_q;

    assign k_m1    = r_k - C_ONE;
    assign last    = r_count - C_ONE;
    assign full    = (r_count == C_FULL);
    assign hit_now = r_pend && (r_rd_data.id == r_id);
    assign age     = r_now - r_rd_data.stamp;
    assign expired = age > {{(STAMP_W-TMO_W){1'b0}}, r_timeout};
    assign search_end = hit_now || (r_ptr == r_count);
    // hit refreshes in place; miss appends, or overwrites the top slot when full
    assign msg_slot = hit_now ? r_pidx : (full ? I_LAST : r_count[IW-1:0]);

    always_comb begin
        case (r_state)
            S_TK_RD:   rd_addr = k_m1[IW-1:0];
            S_TK_TEST: rd_addr = last[IW-1:0];
            default:   rd_addr = r_ptr[IW-1:0];
        endcase
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = msg_slot;
        wr_data = '{id: r_id, stamp: r_now, distance: r_dist};
        if (r_state == S_SEARCH && search_end) begin
            mem_we = 1'b1;
        end else if (r_state == S_TK_MOVE) begin
            mem_we  = 1'b1;
            wr_addr = k_m1[IW-1:0];
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_food_id   <= '0;
            r_timeout   <= TIMEOUT_RST;
            r_res_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_div_start <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FOOD_ID: r_food_id <= i_cfg_data[ID_W-1:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_now   <= i_now;
                        r_id    <= i_sender_id;
                        r_dist  <= i_distance;
                        r_ptr   <= '0;
                        r_pend  <= 1'b0;
                        r_k     <= r_count;
                        r_state <= i_action ? S_SEARCH : S_TK_RD;
                    end
                end
                S_SEARCH: begin
                    if (search_end) begin
                        // entry written this cycle by the memory port
                        if (!hit_now && !full) begin
                            r_count <= r_count + C_ONE;
                        end
                        r_ptr   <= '0;
                        r_pend  <= 1'b0;
                        r_sum   <= '0;
                        r_food  <= 1'b0;
                        r_state <= S_SUM;
                    end else begin
                        r_pend <= 1'b1;
                        r_pidx <= r_ptr[IW-1:0];
                        r_ptr  <= r_ptr + C_ONE;
                    end
                end
                S_TK_RD: begin
                    if (r_k == '0) begin
                        r_ptr   <= '0;
                        r_pend  <= 1'b0;
                        r_sum   <= '0;
                        r_food  <= 1'b0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_TK_TEST;
                    end
                end
                S_TK_TEST: begin
                    if (expired && k_m1 != last) begin
                        r_state <= S_TK_MOVE;
                    end else begin
                        // stale top entry simply drops off the end
                        if (expired) begin
                            r_count <= last;
                        end
                        r_k     <= k_m1;
                        r_state <= S_TK_RD;
                    end
                end
                S_TK_MOVE: begin
                    r_count <= last;
                    r_k     <= k_m1;
                    r_state <= S_TK_RD;
                end
                S_SUM: begin
                    if (r_pend) begin
                        r_sum <= r_sum + SW'(r_rd_data.distance);
                        if (r_rd_data.id == r_food_id) begin
                            r_food <= 1'b1;
                        end
                    end
                    if (r_ptr != r_count) begin
                        r_pend <= 1'b1;
                        r_ptr  <= r_ptr + C_ONE;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res_valid <= 1'b1;
                        r_res_count <= CNT_W'(r_count);
                        r_res_mean  <= (r_count == '0) ? '0 : div_q[DIST_W-1:0];
                        r_res_food  <= r_food;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ntab_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_busy           = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_result_valid   = r_res_valid;
    assign o_neighbor_count = r_res_count;
    assign o_mean_distance  = r_res_mean;
    assign o_food_in_range  = r_res_food;

endmodule

FILE: rtl/ntab_div.sv
// ----------------------------------------------------------------------------
// ntab_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntab_div #(
    parameter int DW = 14,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          ge;

    assign rem_sh  = {r_rem, r_q[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_dividend;
                r_rem <= '0;
                r_dvs <= i_divisor;
            end else if (r_run) begin
                r_rem <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/ntab_chk.sv
// ----------------------------------------------------------------------------
// ntab_chk
// Port-level checks of the neighbour table, bound to the top level.
// ----------------------------------------------------------------------------
module ntab_chk #(
    parameter int MAX_NEIGHBORS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              o_result_valid,
    input logic [ntab_pkg::CNT_W-1:0]        o_neighbor_count,
    input logic [ntab_pkg::DIST_W-1:0]       o_mean_distance,
    input logic                              o_food_in_range
);
    import ntab_pkg::*;

    // accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("item accepted but block not busy");

    // result appears only once the block has gone idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_busy)
        else $error("result strobe while busy");

    // one result per item: strobes never run together
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // empty table reports no distance and no food
    a_empty_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_NEIGHBORS < 32) && o_result_valid && o_neighbor_count == '0
        |-> o_mean_distance == '0 && !o_food_in_range)
        else $error("empty table with non-zero result");

endmodule

bind neighbor_table_with_aging_top ntab_chk #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
) u_ntab_chk (.*);

FILE: sim/tb_neighbor_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// tb_neighbor_table_with_aging_top
// Self-checking bench for the neighbour table: a queue-fed driver issues
// message and tick items, a predictor tracks the table, a monitor checks each
// report against the oldest prediction, across several register settings.
// ----------------------------------------------------------------------------
module tb_neighbor_table_with_aging_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ntab_pkg::*;

    localparam int MAX_NEIGHBORS = 16;
    localparam int DRAIN_CYCLES  = 120;     // longer than the worst item latency
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOWN_ERRORS  = 10;

    // item kinds on i_action
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_MESSAGE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] now;
        logic [ID_W-1:0]    id;
        logic [DIST_W-1:0]  distance;
    } t_table_item;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [DIST_W-1:0] mean;
        logic              food;
    } t_table_report;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic                  o_busy;
    logic                  i_action    = ACT_TICK;
    logic [STAMP_W-1:0]    i_now       = '0;
    logic [ID_W-1:0]       i_sender_id = '0;
    logic [DIST_W-1:0]     i_distance  = '0;
    logic                  o_result_valid;
    logic [CNT_W-1:0]      o_neighbor_count;
    logic [DIST_W-1:0]     o_mean_distance;
    logic                  o_food_in_range;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    neighbor_table_with_aging_top #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_action         (i_action),
        .i_now            (i_now),
        .i_sender_id      (i_sender_id),
        .i_distance       (i_distance),
        .o_result_valid   (o_result_valid),
        .o_neighbor_count (o_neighbor_count),
        .o_mean_distance  (o_mean_distance),
        .o_food_in_range  (o_food_in_range),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_table_item   pending_q[$];        // items waiting to be issued
    t_table_report report_q[$];         // predicted reports, oldest first
    t_table_item   cur_item;            // item currently on the ports

    int sender_idle_pct = 33;
    int gap_left        = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    int reports_checked = 0;
    int messages_sent   = 0;
    int ticks_sent      = 0;
    int full_overwrites = 0;
    int entries_aged    = 0;
    int cfg_writes      = 0;

    // predictor's copy of the table and registers (reset values)
    logic [ID_W-1:0]    table_id    [MAX_NEIGHBORS];
    logic [STAMP_W-1:0] table_stamp [MAX_NEIGHBORS];
    logic [DIST_W-1:0]  table_dist  [MAX_NEIGHBORS];
    int                 table_count = 0;
    logic [ID_W-1:0]    cfg_food_id = '0;
    logic [TMO_W-1:0]   cfg_timeout = TIMEOUT_RST;

    // random-phase traffic shape
    logic [STAMP_W-1:0] now_ctr   = '0;
    logic [ID_W-1:0]    pool_base = '0;
    int                 pool_size = 8;

    // ------------------------------------------------------------------------
    // Predictor: update the table for one item and form the report
    // ------------------------------------------------------------------------
    function automatic t_table_report apply_item(input t_table_item it);
        int                 slot;
        int                 k;
        int                 last;
        int                 sum;
        int                 mean_val;
        bit                 hit;
        logic [STAMP_W-1:0] age;
        t_table_report      rep;

        if (it.action == ACT_MESSAGE) begin
            hit  = 1'b0;
            slot = 0;
            for (k = 0; k < table_count; k++) begin
                if (!hit && table_id[k] == it.id) begin
                    hit  = 1'b1;
                    slot = k;
                end
            end
            if (!hit) begin
                if (table_count < MAX_NEIGHBORS) begin
                    slot = table_count;
                    table_count++;
                end else begin
                    // full: newcomer takes the last slot
                    slot = MAX_NEIGHBORS - 1;
                    full_overwrites++;
                end
            end
            table_id[slot]    = it.id;
            table_stamp[slot] = it.now;
            table_dist[slot]  = it.distance;
        end else begin
            // sweep top down; the entry pulled into a freed slot was already tested
            for (k = table_count; k > 0; k--) begin
                slot = k - 1;
                age  = it.now - table_stamp[slot];
                if (age > cfg_timeout) begin
                    last              = table_count - 1;
                    table_id[slot]    = table_id[last];
                    table_stamp[slot] = table_stamp[last];
                    table_dist[slot]  = table_dist[last];
                    table_count--;
                    entries_aged++;
                end
            end
        end

        sum      = 0;
        rep.food = 1'b0;
        for (k = 0; k < table_count; k++) begin
            sum += table_dist[k];
            if (table_id[k] == cfg_food_id)
                rep.food = 1'b1;
        end
        mean_val  = (table_count > 0) ? sum / table_count : 0;
        rep.mean  = mean_val[DIST_W-1:0];
        rep.count = table_count[CNT_W-1:0];
        return rep;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
            $display("ERROR: %s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : run_watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Item driver: an item is taken on an edge with start high and busy low.
    // start stays high across back-to-back items; the predictor runs on
    // acceptance so the report order matches the issue order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        bit launch;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                report_q.push_back(apply_item(cur_item));
                if (cur_item.action == ACT_MESSAGE)
                    messages_sent++;
                else
                    ticks_sent++;
            end
            // while held off by busy the item just stays on the ports
            if (!(i_start && o_busy)) begin
                launch = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    if ($urandom_range(0, 99) < sender_idle_pct) begin
                        // now and then a long gap so items land on an idle block
                        if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(1, 60);
                    end else begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    cur_item     = pending_q.pop_front();
                    i_start     <= 1'b1;
                    i_action    <= cur_item.action;
                    i_now       <= cur_item.now;
                    i_sender_id <= cur_item.id;
                    i_distance  <= cur_item.distance;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor: one-cycle strobe, checked against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : report_monitor
        t_table_report want;
        t_table_report got;
        if (i_rst_n && o_result_valid) begin
            got.count = o_neighbor_count;
            got.mean  = o_mean_distance;
            got.food  = o_food_in_range;
            if (report_q.size() == 0) begin
                note_failure($sformatf("unexpected report: count %0d mean %0d food %0d",
                                       got.count, got.mean, got.food));
            end else begin
                want = report_q.pop_front();
                if (got.count !== want.count || got.mean !== want.mean ||
                    got.food !== want.food) begin
                    note_failure({
                        $sformatf("report %0d: expected count %0d mean %0d food %0d,",
                                  reports_checked, want.count, want.mean, want.food),
                        $sformatf(" got count %0d mean %0d food %0d",
                                  got.count, got.mean, got.food)});
                end
                reports_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; their queue pushes happen on the falling edge
    // ------------------------------------------------------------------------
    task automatic push_item(input logic act, input logic [STAMP_W-1:0] now,
                             input logic [ID_W-1:0] id,
                             input logic [DIST_W-1:0] distance);
        t_table_item it;
        it.action   = act;
        it.now      = now;
        it.id       = id;
        it.distance = distance;
        pending_q.push_back(it);
    endtask

    // block idle: nothing queued, nothing on the ports, nothing outstanding
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || i_start || report_q.size() != 0 || o_busy);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        // write lands on this edge
        if (idx == CFG_FOOD_ID)
            cfg_food_id = val[ID_W-1:0];
        else if (idx == CFG_TIMEOUT)
            cfg_timeout = val[TMO_W-1:0];
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One random phase: new registers, then mostly plausible traffic (a
    // small id pool so hits, fills and overwrites occur, time moving at a
    // pace tied to the timeout) with some fully random noise items.
    task automatic run_phase(input int idle_pct, input logic [ID_W-1:0] food,
                             input logic [TMO_W-1:0] tmo, input int n_items);
        int          n;
        int          step_max;
        t_table_item it;

        wait_until_idle();
        sender_idle_pct = idle_pct;
        write_register(CFG_FOOD_ID, {{(CFG_DATA_W-ID_W){1'b0}}, food});
        write_register(CFG_TIMEOUT, tmo);

        pool_size = $urandom_range(4, 40);
        pool_base = ID_W'($urandom);
        step_max  = cfg_timeout / 4 + 1;
        if ($urandom_range(0, 1) == 0)
            now_ctr = $urandom;
        else
            now_ctr = 32'hFFFF_FFFF - $urandom_range(0, 4 * cfg_timeout + 64); // wraps soon

        for (n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < 10) begin
                it.action   = 1'($urandom_range(0, 1));
                it.now      = $urandom;
                it.id       = ID_W'($urandom);
                it.distance = DIST_W'($urandom);
            end else begin
                now_ctr   = now_ctr + $urandom_range(0, step_max);
                it.action = ($urandom_range(0, 99) < 30) ? ACT_TICK : ACT_MESSAGE;
                it.now    = now_ctr;
                if ($urandom_range(0, 9) == 0)
                    it.id = cfg_food_id;
                else
                    it.id = ID_W'(pool_base + $urandom_range(0, pool_size - 1));
                it.distance = DIST_W'($urandom);
            end
            pending_q.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int n;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at reset settings (food id 0, timeout 32)
        push_item(ACT_TICK,    32'd0,          8'd0,   8'd0);   // tick, empty table
        push_item(ACT_MESSAGE, 32'd0,          8'd0,   8'd255); // food beacon heard
        push_item(ACT_MESSAGE, 32'hFFFF_FFFF,  8'd255, 8'd0);
        push_item(ACT_MESSAGE, 32'd5,          8'd0,   8'd10);  // hit, refresh
        // age 32 is kept, age 38 across the wrap is dropped
        push_item(ACT_TICK,    32'd37,         8'd0,   8'd0);
        // fill to sixteen, then one more newcomer overwrites the last slot
        for (n = 1; n <= 16; n++)
            push_item(ACT_MESSAGE, 32'd40, n[ID_W-1:0], 8'd255);
        push_item(ACT_MESSAGE, 32'd60,         8'd1,   8'd7);
        // everything but id 1 stale: sweep moves id 1 down into slot 0
        push_item(ACT_TICK,    32'd73,         8'd0,   8'd0);
        push_item(ACT_TICK,    32'hFFFF_FFFF,  8'hFF,  8'hFF);  // drops the rest
        push_item(ACT_TICK,    32'hFFFF_FFFF,  8'hFF,  8'hFF);  // empty again

        // sender idles 33 in 100, then 55, then not at all
        run_phase(33, 8'hFF, 16'd0, 100);
        run_phase(33, 8'($urandom), 16'hFFFF, 100);
        run_phase(55, 8'h00, 16'($urandom_range(1, 40)), 100);
        run_phase(55, 8'($urandom), 16'($urandom_range(0, 300)), 100);
        run_phase(0,  8'hFF, 16'($urandom_range(8, 64)), 100);
        run_phase(0,  8'($urandom), 16'($urandom), 100);

        wait_until_idle();
        if (report_q.size() != 0)
            note_failure($sformatf("%0d predicted reports never arrived", report_q.size()));

        $display("Run: %0d message and %0d tick items, %0d reports checked, %0d mismatches",
                 messages_sent, ticks_sent, reports_checked, fail_count);
        $display("Table: %0d full-table overwrites, %0d entries aged out, %0d register writes",
                 full_overwrites, entries_aged, cfg_writes);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
